/* rtl/tic_pkg.sv */
// tic_pkg: shared constants, status codes and the item record that travels
// down the cell chain of tensor_index_converter. No dependencies.
package tic_pkg;

    localparam int NDIMS         = 4;
    localparam int DIM_BITS      = 16;
    localparam int FLAT_BITS     = 32;
    localparam int RANK_BITS     = 3;
    localparam int DIV_STEPS     = 4;
    localparam int CELLS_PER_DIM = FLAT_BITS / DIV_STEPS;
    localparam int DIV_CELLS     = NDIMS * CELLS_PER_DIM;
    localparam int DIM_CELLS     = NDIMS;
    localparam int CHAIN_LEN     = DIM_CELLS + DIV_CELLS;
    localparam int PROD_BITS     = FLAT_BITS + DIM_BITS;
    localparam int SEL_BITS      = $clog2(NDIMS);

    // register indexes on the configuration port
    localparam logic [2:0] REG_RANK  = 3'd0;
    localparam logic [2:0] REG_DIM_0 = 3'd1;
    localparam logic [2:0] REG_DIM_1 = 3'd2;
    localparam logic [2:0] REG_DIM_2 = 3'd3;
    localparam logic [2:0] REG_DIM_3 = 3'd4;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_INVALID_SHAPE = 2'd1,
        ST_OUT_OF_BOUNDS = 2'd2,
        ST_OVERFLOW      = 2'd3
    } status_t;

    typedef logic [NDIMS-1:0][DIM_BITS-1:0] coord_vec_t;

    // one item in flight: both conversions run side by side
    typedef struct packed {
        logic                 mode;
        logic [FLAT_BITS-1:0] flat_org;   // index as received
        logic [FLAT_BITS-1:0] num;        // running dividend / quotient
        logic [DIM_BITS-1:0]  part;       // partial remainder
        coord_vec_t           coord_in;
        coord_vec_t           coord_out;
        status_t              st;         // coordinate-to-index status
        logic                 ovf;        // pending overflow inside a dim cell
        logic [FLAT_BITS-1:0] stride;     // running stride, exact while !big
        logic                 big;        // stride beyond the flat range
        logic [FLAT_BITS-1:0] acc;        // running flat index
        logic [PROD_BITS-1:0] prod;       // coord * stride
        logic [PROD_BITS-1:0] sprod;      // stride * dim
    } item_t;

endpackage

/* rtl/tic_dim_cell.sv */
// tic_dim_cell: one dimension of the coordinate-to-index walk, two stages
// (multiply, then accumulate and check). Depends on tic_pkg.
module tic_dim_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  tic_pkg::item_t                      in_item,
    input  logic [tic_pkg::DIM_BITS-1:0]        dim,
    input  logic                                use_dim,
    input  logic [tic_pkg::SEL_BITS-1:0]        sel,
    output logic                                out_valid,
    output tic_pkg::item_t                      out_item
);

    tic_pkg::item_t                 a_reg, a_next, b_reg, b_next;
    logic                           a_valid_reg, b_valid_reg;
    logic [tic_pkg::DIM_BITS-1:0]   c, d;
    logic [tic_pkg::FLAT_BITS:0]    sum;

    // stage a: bounds checks and the two products
    always_comb begin
        c = use_dim ? in_item.coord_in[sel] : '0;
        d = use_dim ? dim : tic_pkg::DIM_BITS'(1);
        a_next = in_item;
        a_next.prod  = c * in_item.stride;
        a_next.sprod = in_item.stride * d;
        a_next.ovf   = in_item.big && (c != '0);
        if (in_item.st == tic_pkg::ST_OK) begin
            if (d == '0) begin
                a_next.st = tic_pkg::ST_INVALID_SHAPE;
            end else if (c >= d) begin
                a_next.st = tic_pkg::ST_OUT_OF_BOUNDS;
            end
        end
    end

    // stage b: accumulate, overflow check, next stride
    always_comb begin
        sum = {1'b0, a_reg.acc} + a_reg.prod[tic_pkg::FLAT_BITS:0];
        b_next = a_reg;
        if (a_reg.st == tic_pkg::ST_OK && (a_reg.ovf || sum[tic_pkg::FLAT_BITS]
                || a_reg.prod[tic_pkg::PROD_BITS-1:tic_pkg::FLAT_BITS] != '0)) begin
            b_next.st = tic_pkg::ST_OVERFLOW;
        end
        b_next.acc    = sum[tic_pkg::FLAT_BITS-1:0];
        b_next.stride = a_reg.sprod[tic_pkg::FLAT_BITS-1:0];
        b_next.big    = a_reg.big
                      || (a_reg.sprod[tic_pkg::PROD_BITS-1:tic_pkg::FLAT_BITS] != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_reg;

endmodule

/* rtl/tic_div_cell.sv */
// tic_div_cell: a few restoring-division steps of the index-to-coordinate
// walk; the last cell of a dimension stores the remainder. Depends on tic_pkg.
module tic_div_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  tic_pkg::item_t                      in_item,
    input  logic [tic_pkg::DIM_BITS-1:0]        dim,
    input  logic                                use_dim,
    input  logic [tic_pkg::SEL_BITS-1:0]        sel,
    input  logic                                last,
    output logic                                out_valid,
    output tic_pkg::item_t                      out_item
);

    tic_pkg::item_t                 q_reg, q_next;
    logic                           valid_reg;
    logic [tic_pkg::DIM_BITS-1:0]   d, p;
    logic [tic_pkg::DIM_BITS:0]     t;
    logic [tic_pkg::FLAT_BITS-1:0]  n;

    // shift-compare-subtract, one quotient bit per step
    always_comb begin
        d = use_dim ? dim : tic_pkg::DIM_BITS'(1);
        p = in_item.part;
        n = in_item.num;
        t = '0;
        for (int k = 0; k < tic_pkg::DIV_STEPS; k++) begin
            t = {p, n[tic_pkg::FLAT_BITS-1]};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
                n = {n[tic_pkg::FLAT_BITS-2:0], 1'b1};
            end else begin
                n = {n[tic_pkg::FLAT_BITS-2:0], 1'b0};
            end
            p = t[tic_pkg::DIM_BITS-1:0];
        end
        q_next = in_item;
        q_next.num  = n;
        q_next.part = p;
        if (last) begin
            q_next.coord_out[sel] = p;
            q_next.part           = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = q_reg;

endmodule

/* rtl/tensor_index_converter.sv */
// tensor_index_converter: row-major coordinate <-> flat index conversion
// as a chain of dimension cells and division cells. Depends on tic_pkg,
// tic_dim_cell and tic_div_cell.
//
//  channel   direction  payload
//  s_*       in         tuser: mode; tdata: flat_in, coord_in_0..3
//  m_*       out        tuser: status; tdata: flat_out, coord_out_0..3
//  cfg_*     in         addr 0 rank, 1..4 dim_0..dim_3; write only
//
// One item per cycle while the skid entry is empty; an item passes the four
// dimension cells (multiply stage plus accumulate stage each), then the
// division cells (4 quotient bits per cell, 8 cells per dimension), then the
// output register. Reset sets rank 1 and all dimensions to 1 and empties the chain.
// The chain halts while the skid entry holds an item; s_tready comes from
// a register, so the output stall never reaches the input combinationally.
module tensor_index_converter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [95:0]                         s_tdata,  // flat_in, coord_in_0..3
    input  logic                                s_tuser,  // mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [95:0]                         m_tdata,  // flat_out, coord_out_0..3
    output logic [1:0]                          m_tuser,  // status
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_addr,
    input  logic [tic_pkg::DIM_BITS-1:0]        cfg_wdata
);

    logic [tic_pkg::RANK_BITS-1:0]  rank_reg;
    tic_pkg::coord_vec_t            dim_reg;
    logic [tic_pkg::RANK_BITS-1:0]  r_used;
    logic [tic_pkg::NDIMS-1:0]      use_dim;
    logic                           any_zero;

    tic_pkg::item_t                 chain [0:tic_pkg::CHAIN_LEN];
    logic                           chain_v [0:tic_pkg::CHAIN_LEN];
    logic                           en;

    tic_pkg::item_t                 fin;
    tic_pkg::status_t               res_st;
    logic [95:0]                    res_data;

    logic                           out_valid_reg, skid_valid_reg;
    logic [95:0]                    out_data_reg, skid_data_reg;
    logic [1:0]                     out_user_reg, skid_user_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= tic_pkg::RANK_BITS'(1);
            for (int i = 0; i < tic_pkg::NDIMS; i++) begin
                dim_reg[i] <= tic_pkg::DIM_BITS'(1);
            end
        end else if (cfg_we) begin
            case (cfg_addr)
                tic_pkg::REG_RANK:  rank_reg   <= cfg_wdata[tic_pkg::RANK_BITS-1:0];
                tic_pkg::REG_DIM_0: dim_reg[0] <= cfg_wdata;
                tic_pkg::REG_DIM_1: dim_reg[1] <= cfg_wdata;
                tic_pkg::REG_DIM_2: dim_reg[2] <= cfg_wdata;
                tic_pkg::REG_DIM_3: dim_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // dimensions in use
    always_comb begin
        r_used = (rank_reg > tic_pkg::RANK_BITS'(tic_pkg::NDIMS))
               ? tic_pkg::RANK_BITS'(tic_pkg::NDIMS) : rank_reg;
        any_zero = 1'b0;
        for (int i = 0; i < tic_pkg::NDIMS; i++) begin
            use_dim[i] = tic_pkg::RANK_BITS'(i) < r_used;
            if (use_dim[i] && dim_reg[i] == '0) begin
                any_zero = 1'b1;
            end
        end
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // item entering the chain
    always_comb begin
        chain[0]           = '0;
        chain[0].mode      = s_tuser;
        chain[0].flat_org  = s_tdata[31:0];
        chain[0].num       = s_tdata[31:0];
        for (int i = 0; i < tic_pkg::NDIMS; i++) begin
            chain[0].coord_in[i] = s_tdata[32 + 16*i +: 16];
        end
        chain[0].st        = tic_pkg::ST_OK;
        chain[0].stride    = tic_pkg::FLAT_BITS'(1);
        chain_v[0]         = s_tvalid;
    end

    // dimension cells, innermost dimension first
    for (genvar j = 0; j < tic_pkg::DIM_CELLS; j++) begin : g_dim
        tic_dim_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_v[j]),
            .in_item   (chain[j]),
            .dim       (dim_reg[tic_pkg::NDIMS-1-j]),
            .use_dim   (use_dim[tic_pkg::NDIMS-1-j]),
            .sel       (tic_pkg::SEL_BITS'(tic_pkg::NDIMS-1-j)),
            .out_valid (chain_v[j+1]),
            .out_item  (chain[j+1])
        );
    end

    // division cells, innermost dimension first
    for (genvar j = 0; j < tic_pkg::DIV_CELLS; j++) begin : g_div
        localparam int DI = tic_pkg::NDIMS - 1 - j / tic_pkg::CELLS_PER_DIM;
        tic_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_v[tic_pkg::DIM_CELLS+j]),
            .in_item   (chain[tic_pkg::DIM_CELLS+j]),
            .dim       (dim_reg[DI]),
            .use_dim   (use_dim[DI]),
            .sel       (tic_pkg::SEL_BITS'(DI)),
            .last      ((j % tic_pkg::CELLS_PER_DIM) == tic_pkg::CELLS_PER_DIM - 1),
            .out_valid (chain_v[tic_pkg::DIM_CELLS+j+1]),
            .out_item  (chain[tic_pkg::DIM_CELLS+j+1])
        );
    end

    // final status and result fields
    always_comb begin
        fin      = chain[tic_pkg::CHAIN_LEN];
        res_data = '0;
        if (r_used == '0) begin
            res_st = tic_pkg::ST_INVALID_SHAPE;
        end else if (!fin.mode) begin
            res_st = fin.st;
        end else if (any_zero) begin
            res_st = tic_pkg::ST_INVALID_SHAPE;
        end else if (fin.big) begin
            res_st = tic_pkg::ST_OVERFLOW;
        end else if (fin.flat_org >= fin.stride) begin
            res_st = tic_pkg::ST_OUT_OF_BOUNDS;
        end else begin
            res_st = tic_pkg::ST_OK;
        end
        if (res_st == tic_pkg::ST_OK) begin
            if (!fin.mode) begin
                res_data[31:0] = fin.acc;
            end else begin
                res_data[95:32] = fin.coord_out;
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_tready) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (chain_v[tic_pkg::CHAIN_LEN]) begin
                if (out_valid_reg && !m_tready) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end else if (chain_v[tic_pkg::CHAIN_LEN]) begin
            if (out_valid_reg && !m_tready) begin
                skid_data_reg <= res_data;
                skid_user_reg <= res_st;
            end else begin
                out_data_reg <= res_data;
                out_user_reg <= res_st;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // checks
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output item");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("skid entry dropped while output stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != tic_pkg::ST_OK |-> m_tdata == '0)
        else $error("error result with nonzero payload");

    a_one_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:0] == '0 || m_tdata[95:32] == '0))
        else $error("flat index and coordinates both nonzero");

endmodule

/* bench/tensor_index_converter_test.sv */
// tensor_index_converter_test: self-checking bench for the coordinate and flat index
// converter, with a local predictor, random stream idling and register phases.
// Depends on tic_pkg and tensor_index_converter.
module tensor_index_converter_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        tic_pkg::status_t     st;
        logic [31:0]          flat;
        tic_pkg::coord_vec_t  coord;
    } conv_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;    // flat_in, coord_in_0..3
    logic        s_tuser = 1'b0;  // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;         // flat_out, coord_out_0..3
    logic [1:0]  m_tuser;         // status
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = tic_pkg::REG_RANK;
    logic [15:0] cfg_wdata = '0;

    // local copy of the shape registers
    logic [2:0]  shape_rank;
    logic [15:0] shape_dim [tic_pkg::NDIMS];

    conv_result_t pending_results [$];
    int          mismatches = 0;
    int          gap_style = 0;    // 0 no gaps, 1 bursts with gaps
    int          ready_style = 0;  // 0 always, 1 random, 2 periodic
    int          burst_left = 0;
    int unsigned ready_phase = 0;

    tensor_index_converter u_top (.*);

    always #4 aclk = ~aclk;

    // converter predictor, row-major with innermost dimension last
    function automatic conv_result_t convert_item(logic mode, logic [31:0] flat_in,
                                                  tic_pkg::coord_vec_t cin);
        conv_result_t res;
        int          r;
        logic [63:0] flat, stride, count, rem, d;
        logic        zero;
        res = '{st: tic_pkg::ST_OK, flat: '0, coord: '0};
        r = (shape_rank > 3'd4) ? 4 : int'(shape_rank);
        if (r == 0) begin
            res.st = tic_pkg::ST_INVALID_SHAPE;
        end else if (mode == 1'b0) begin
            flat = 0;
            stride = 1;
            for (int i = r - 1; i >= 0; i--) begin
                d = shape_dim[i];
                if (d == 0) begin
                    res.st = tic_pkg::ST_INVALID_SHAPE;
                    break;
                end
                if (cin[i] >= d) begin
                    res.st = tic_pkg::ST_OUT_OF_BOUNDS;
                    break;
                end
                flat = flat + cin[i] * stride;
                if (flat > 64'hFFFF_FFFF) begin
                    res.st = tic_pkg::ST_OVERFLOW;
                    break;
                end
                stride = stride * d;
            end
            if (res.st == tic_pkg::ST_OK) res.flat = flat[31:0];
        end else begin
            zero = 1'b0;
            count = 1;
            for (int i = 0; i < r; i++) begin
                if (shape_dim[i] == 0) zero = 1'b1;
                count = count * shape_dim[i];
            end
            if (zero) begin
                res.st = tic_pkg::ST_INVALID_SHAPE;
            end else if (count > 64'hFFFF_FFFF) begin
                res.st = tic_pkg::ST_OVERFLOW;
            end else if (flat_in >= count) begin
                res.st = tic_pkg::ST_OUT_OF_BOUNDS;
            end else begin
                rem = flat_in;
                for (int i = r - 1; i >= 0; i--) begin
                    res.coord[i] = 16'(rem % shape_dim[i]);
                    rem = rem / shape_dim[i];
                end
            end
        end
        return res;
    endfunction

    // element count of the current shape, 64 bits wide
    function automatic logic [63:0] element_count();
        logic [63:0] count;
        int          r;
        r = (shape_rank > 3'd4) ? 4 : int'(shape_rank);
        count = 1;
        for (int i = 0; i < r; i++) count = count * shape_dim[i];
        return count;
    endfunction

    // receiver stall pattern
    always @(posedge aclk) begin
        ready_phase <= ready_phase + 1;
        case (ready_style)
            1: m_tready <= ($urandom_range(0, 9) > 3);
            2: m_tready <= ((ready_phase % 11) > 3);
            default: m_tready <= 1'b1;
        endcase
    end

    // result checker
    always @(posedge aclk) begin
        conv_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{st: tic_pkg::status_t'(m_tuser), flat: m_tdata[31:0],
                    coord: m_tdata[95:32]};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: status %0d flat %h coords %h",
                             got.st, got.flat, got.coord);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want st %0d flat %h coords %h, got st %0d flat %h coords %h",
                                 want.st, want.flat, want.coord,
                                 got.st, got.flat, got.coord);
                end
            end
        end
    end

    // register write, mirrored into the local shape
    task automatic write_reg(logic [2:0] addr, logic [15:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr == tic_pkg::REG_RANK) shape_rank = value[2:0];
        else if (addr <= tic_pkg::REG_DIM_3) shape_dim[2'(addr - 3'd1)] = value;
    endtask

    task automatic set_shape(logic [2:0] r, logic [15:0] d0, logic [15:0] d1,
                             logic [15:0] d2, logic [15:0] d3);
        write_reg(tic_pkg::REG_RANK, {13'd0, r});
        write_reg(tic_pkg::REG_DIM_0, d0);
        write_reg(tic_pkg::REG_DIM_1, d1);
        write_reg(tic_pkg::REG_DIM_2, d2);
        write_reg(tic_pkg::REG_DIM_3, d3);
    endtask

    // send one item, idling between bursts
    task automatic send_item(logic mode, logic [31:0] flat_in, tic_pkg::coord_vec_t cin);
        if (gap_style != 0) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {cin, flat_in};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(convert_item(mode, flat_in, cin));
    endtask

    // stop sending and let every expected item come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (48) @(posedge aclk);
    endtask

    task automatic test_reset_shape();
        send_item(1'b0, 32'd0, '0);
        send_item(1'b0, 32'd0, {16'd0, 16'd0, 16'd0, 16'd1});
        send_item(1'b1, 32'd0, '0);
        send_item(1'b1, 32'd5, '0);
        drain();
    endtask

    task automatic test_corner_shapes();
        // largest dimensions: count and index overflow
        set_shape(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(1'b1, 32'hFFFF_FFFF, '0);
        send_item(1'b0, 32'd0, {4{16'hFFFE}});
        send_item(1'b0, 32'd0, {16'h0001, 16'd0, 16'h0002, 16'd0});
        send_item(1'b0, 32'd0, {4{16'hFFFF}});
        drain();
        // empty shape
        write_reg(tic_pkg::REG_RANK, 16'd0);
        send_item(1'b0, 32'd0, '0);
        send_item(1'b1, 32'd0, '0);
        drain();
        // rank above four, zero inner dimension, then zero outer one
        set_shape(3'd7, 16'd3, 16'd5, 16'd7, 16'd0);
        send_item(1'b0, 32'd0, {16'd9, 16'd1, 16'd1, 16'd1});
        send_item(1'b1, 32'd1, '0);
        drain();
        set_shape(3'd2, 16'd0, 16'd5, 16'd0, 16'd0);
        send_item(1'b0, 32'd0, {16'd0, 16'd0, 16'd7, 16'd0});
        send_item(1'b0, 32'd0, {16'd0, 16'd0, 16'd2, 16'd0});
        send_item(1'b1, 32'd0, '0);
        drain();
        // exact 2^32 elements: overflow in index mode, last index in coord mode
        set_shape(3'd2, 16'hFFFF, 16'h0000, 16'd0, 16'd0);
        set_shape(3'd3, 16'd4, 16'h8000, 16'h8000, 16'd9);
        send_item(1'b1, 32'hFFFF_FFFF, '0);
        send_item(1'b0, 32'd0, {16'd0, 16'h7FFF, 16'h7FFF, 16'd3});
        drain();
        set_shape(3'd4, 16'd2, 16'd3, 16'd4, 16'd5);
        send_item(1'b1, 32'd119, '0);
        send_item(1'b1, 32'd120, '0);
        send_item(1'b0, 32'd0, {16'd4, 16'd3, 16'd2, 16'd1});
        send_item(1'b0, 32'hFFFF_FFFF, '0);
        drain();
    endtask

    // random shapes, mostly in-range items
    task automatic test_random_phase(int items);
        logic [15:0]         d [tic_pkg::NDIMS];
        logic [63:0]         count;
        tic_pkg::coord_vec_t cin;
        logic [31:0]         flat_in;
        logic                mode;
        for (int i = 0; i < tic_pkg::NDIMS; i++) begin
            case ($urandom_range(0, 19))
                0: d[i] = 16'd0;
                1: d[i] = 16'hFFFF;
                2: d[i] = $urandom_range(1, 65535);
                default: d[i] = $urandom_range(1, 12);
            endcase
        end
        set_shape(($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(1, 4)),
                  d[0], d[1], d[2], d[3]);
        gap_style = $urandom_range(0, 1);
        ready_style = $urandom_range(0, 2);
        count = element_count();
        repeat (items) begin
            mode = $urandom_range(0, 1);
            flat_in = $urandom;
            for (int i = 0; i < tic_pkg::NDIMS; i++)
                cin[i] = (shape_dim[i] != 0 && $urandom_range(0, 9) != 0)
                         ? 16'($urandom_range(0, shape_dim[i] - 1)) : 16'($urandom);
            if (count != 0 && count <= 64'h1_0000_0000) begin
                case ($urandom_range(0, 19))
                    0: flat_in = 32'(count - 64'd1);
                    1: flat_in = count[31:0];
                    2, 3: ;
                    default: flat_in = 32'({$urandom, $urandom} % count);
                endcase
            end
            send_item(mode, flat_in, cin);
        end
        drain();
    endtask

    initial begin
        shape_rank = 3'd1;
        for (int i = 0; i < tic_pkg::NDIMS; i++) shape_dim[i] = 16'd1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_shape();
        gap_style = 1;
        ready_style = 1;
        test_corner_shapes();
        for (int p = 0; p < 26; p++) test_random_phase(50);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end
endmodule
